@@ rtl/seg_pkg.sv @@
// Shared widths, register indexes and stage bundles for the segment collision block.
package seg_pkg;

  localparam int CW  = 24;
  localparam int DW  = 25;
  localparam int MW  = 50;
  localparam int SQW = 49;
  localparam int C2W = 48;
  localparam int RW  = 23;
  localparam int R2W = 46;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_START_X = 2'd0;
  localparam reg_idx_t REG_START_Y = 2'd1;
  localparam reg_idx_t REG_END_X   = 2'd2;
  localparam reg_idx_t REG_END_Y   = 2'd3;

  typedef struct packed {
    logic           hit;
    logic           zero;
    logic           neg_x;
    logic           neg_y;
    logic [C2W-1:0] c2_x;
    logic [C2W-1:0] c2_y;
    logic [SQW-1:0] sq;
  } geo_t;

  typedef struct packed {
    logic           on_seg;
    logic           near_end;
    logic           len_ok;
    logic           neg_x;
    logic           neg_y;
    logic [C2W-1:0] c2_x;
    logic [C2W-1:0] c2_y;
    logic [SQW-1:0] sq;
  } side_t;

endpackage

@@ rtl/segment_collision_normal.sv @@
// Top level of the point-against-segment collision block with unit normal output.
// Throughput: one word per cycle while out_ready takes each result; the geometry pipeline
// and one search stage per magnitude bit of the normal each take a new word every
// enabled cycle, and a skid stage keeps input open for one more word while a result is
// held. Reset clears all valid bits and the segment to zero.
module segment_collision_normal #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  seg_pkg::coord_t               pos_x,
  input  seg_pkg::coord_t               pos_y,
  input  logic [seg_pkg::RW-1:0]        radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] normal_y,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  seg_pkg::reg_idx_t             cfg_index,
  input  seg_pkg::coord_t               cfg_data
);
  import seg_pkg::*;

  localparam int VW = NORMAL_FRAC_BITS + 2;

  coord_t a_x, a_y, b_x, b_y;
  logic en;
  logic geo_valid;
  geo_t geo;
  logic pv, pv_y, res_hit, unused_tag;
  logic signed [VW-1:0] res_nx, res_ny;
  logic skid_valid, skid_hit;
  logic signed [VW-1:0] skid_nx, skid_ny;

  assign cfg_ready = 1'b1;
  assign en        = !skid_valid;
  assign in_ready  = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_x <= '0;
      a_y <= '0;
      b_x <= '0;
      b_y <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_X: a_x <= cfg_data;
        REG_START_Y: a_y <= cfg_data;
        REG_END_X:   b_x <= cfg_data;
        REG_END_Y:   b_y <= cfg_data;
        default: ;
      endcase
    end
  end

  seg_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .radius    (radius),
    .a_x       (a_x),
    .a_y       (a_y),
    .b_x       (b_x),
    .b_y       (b_y),
    .out_valid (geo_valid),
    .geo       (geo)
  );

  seg_unit #(.FRAC(NORMAL_FRAC_BITS)) u_unit_x (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (geo_valid),
    .c2        (geo.c2_x),
    .sq        (geo.sq),
    .neg       (geo.neg_x),
    .zero      (geo.zero),
    .tag       (geo.hit),
    .out_valid (pv),
    .out_tag   (res_hit),
    .value     (res_nx)
  );

  seg_unit #(.FRAC(NORMAL_FRAC_BITS)) u_unit_y (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (geo_valid),
    .c2        (geo.c2_y),
    .sq        (geo.sq),
    .neg       (geo.neg_y),
    .zero      (geo.zero),
    .tag       (geo.hit),
    .out_valid (pv_y),
    .out_tag   (unused_tag),
    .value     (res_ny)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= pv && pv_y;
      end
    end else if (pv && en) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        hit      <= skid_hit;
        normal_x <= skid_nx;
        normal_y <= skid_ny;
      end else begin
        hit      <= res_hit;
        normal_x <= res_nx;
        normal_y <= res_ny;
      end
    end else if (pv && en) begin
      skid_hit <= res_hit && !unused_tag ? res_hit : res_hit;
      skid_nx  <= res_nx;
      skid_ny  <= res_ny;
    end
  end

endmodule

@@ rtl/seg_mul.sv @@
// Two-stage unsigned multiplier built from four registered partial products.
module seg_mul #(
  parameter int WA = 49,
  parameter int WB = 49
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int LA = (WA + 1) / 2;
  localparam int LB = (WB + 1) / 2;
  localparam int UA = WA - LA;
  localparam int UB = WB - LB;
  localparam int PW = WA + WB;

  logic [LA+LB-1:0] pll;
  logic [LA+UB-1:0] plh;
  logic [UA+LB-1:0] phl;
  logic [UA+UB-1:0] phh;

  always_ff @(posedge clk) begin
    if (en) begin
      pll <= a[LA-1:0] * b[LB-1:0];
      plh <= a[LA-1:0] * b[WB-1:LB];
      phl <= a[WA-1:LA] * b[LB-1:0];
      phh <= a[WA-1:LA] * b[WB-1:LB];
      p   <= {phh, pll} + (PW'(plh) << LB) + (PW'(phl) << LA);
    end
  end

endmodule

@@ rtl/seg_geom.sv @@
// Geometry pipeline: differences, products, inside test, distance compare and normal choice.
module seg_geom (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  seg_pkg::coord_t        pos_x,
  input  seg_pkg::coord_t        pos_y,
  input  logic [seg_pkg::RW-1:0] radius,
  input  seg_pkg::coord_t        a_x,
  input  seg_pkg::coord_t        a_y,
  input  seg_pkg::coord_t        b_x,
  input  seg_pkg::coord_t        b_y,
  output logic                   out_valid,
  output seg_pkg::geo_t          geo
);
  import seg_pkg::*;

  typedef struct packed {
    logic gt_abx;
    logic lt_abx;
    logic gt_aby;
    logic lt_aby;
    logic gt_cax;
    logic gt_cay;
    logic gt_cbx;
    logic gt_cby;
  } sgn_t;

  logic v1, v2, v3, v4, v5, v6;

  logic signed [DW-1:0] cax, cay, cbx, cby, abx, aby;
  logic [RW-1:0] r1;

  logic signed [MW-1:0] m_da_x, m_da_y, m_db_x, m_db_y, m_x1, m_x2, m_f1, m_f2;
  logic signed [MW-1:0] s_cax, s_cay, s_cbx, s_cby, s_abx, s_aby;
  logic [R2W-1:0] r2_2;
  sgn_t sg2;

  logic signed [MW-1:0] dot_a, dot_b, cross3, flip3;
  logic [SQW-1:0] sqa, sqb, len2_3;
  logic [C2W-1:0] c2_cax, c2_cay, c2_cbx, c2_cby, c2_abx, c2_aby;
  logic [R2W-1:0] r2_3;
  sgn_t sg3;

  side_t side_next, side4, side5, side6;
  logic [SQW-1:0] cr4, len2_4;
  logic [R2W-1:0] r2_4;
  logic on_seg, flip, sel_a;

  logic [2*SQW-1:0]   crsq;
  logic [R2W+SQW-1:0] rl;
  logic near;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cax <= DW'(pos_x) - DW'(a_x);
      cay <= DW'(pos_y) - DW'(a_y);
      cbx <= DW'(pos_x) - DW'(b_x);
      cby <= DW'(pos_y) - DW'(b_y);
      abx <= DW'(b_x) - DW'(a_x);
      aby <= DW'(b_y) - DW'(a_y);
      r1  <= radius;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_da_x <= MW'(cax) * MW'(abx);
      m_da_y <= MW'(cay) * MW'(aby);
      m_db_x <= MW'(cbx) * MW'(abx);
      m_db_y <= MW'(cby) * MW'(aby);
      m_x1   <= MW'(cax) * MW'(cby);
      m_x2   <= MW'(cbx) * MW'(cay);
      m_f1   <= MW'(cay) * MW'(abx);
      m_f2   <= MW'(cax) * MW'(aby);
      s_cax  <= MW'(cax) * MW'(cax);
      s_cay  <= MW'(cay) * MW'(cay);
      s_cbx  <= MW'(cbx) * MW'(cbx);
      s_cby  <= MW'(cby) * MW'(cby);
      s_abx  <= MW'(abx) * MW'(abx);
      s_aby  <= MW'(aby) * MW'(aby);
      r2_2   <= R2W'(r1) * R2W'(r1);
      sg2.gt_abx <= !abx[DW-1] && (abx != '0);
      sg2.lt_abx <= abx[DW-1];
      sg2.gt_aby <= !aby[DW-1] && (aby != '0);
      sg2.lt_aby <= aby[DW-1];
      sg2.gt_cax <= !cax[DW-1] && (cax != '0);
      sg2.gt_cay <= !cay[DW-1] && (cay != '0);
      sg2.gt_cbx <= !cbx[DW-1] && (cbx != '0);
      sg2.gt_cby <= !cby[DW-1] && (cby != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dot_a  <= m_da_x + m_da_y;
      dot_b  <= m_db_x + m_db_y;
      cross3 <= m_x1 - m_x2;
      flip3  <= m_f1 - m_f2;
      sqa    <= SQW'(s_cax + s_cay);
      sqb    <= SQW'(s_cbx + s_cby);
      len2_3 <= SQW'(s_abx + s_aby);
      c2_cax <= C2W'(s_cax);
      c2_cay <= C2W'(s_cay);
      c2_cbx <= C2W'(s_cbx);
      c2_cby <= C2W'(s_cby);
      c2_abx <= C2W'(s_abx);
      c2_aby <= C2W'(s_aby);
      r2_3   <= r2_2;
      sg3    <= sg2;
    end
  end

  assign on_seg = (dot_a > 0) && (dot_b < 0);
  assign flip   = flip3 < 0;
  assign sel_a  = sqa < sqb;

  always_comb begin
    side_next.on_seg   = on_seg;
    side_next.len_ok   = len2_3 >= SQW'(r2_3);
    side_next.near_end = sel_a ? (sqa <= SQW'(r2_3)) : (sqb <= SQW'(r2_3));
    if (on_seg) begin
      side_next.neg_x = flip ? sg3.lt_aby : sg3.gt_aby;
      side_next.neg_y = flip ? sg3.gt_abx : sg3.lt_abx;
      side_next.c2_x  = c2_aby;
      side_next.c2_y  = c2_abx;
      side_next.sq    = len2_3;
    end else if (sel_a) begin
      side_next.neg_x = sg3.gt_cax;
      side_next.neg_y = sg3.gt_cay;
      side_next.c2_x  = c2_cax;
      side_next.c2_y  = c2_cay;
      side_next.sq    = sqa;
    end else begin
      side_next.neg_x = sg3.gt_cbx;
      side_next.neg_y = sg3.gt_cby;
      side_next.c2_x  = c2_cbx;
      side_next.c2_y  = c2_cby;
      side_next.sq    = sqb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4  <= side_next;
      cr4    <= cross3[MW-1] ? SQW'(-cross3) : SQW'(cross3);
      len2_4 <= len2_3;
      r2_4   <= r2_3;
      side5  <= side4;
      side6  <= side5;
    end
  end

  seg_mul #(.WA(SQW), .WB(SQW)) u_mul_cr (
    .clk (clk),
    .en  (en),
    .a   (cr4),
    .b   (cr4),
    .p   (crsq)
  );

  seg_mul #(.WA(R2W), .WB(SQW)) u_mul_rl (
    .clk (clk),
    .en  (en),
    .a   (r2_4),
    .b   (len2_4),
    .p   (rl)
  );

  assign near = side6.on_seg ? (crsq <= (2*SQW)'(rl)) : side6.near_end;

  always_ff @(posedge clk) begin
    if (en) begin
      geo.hit   <= near && side6.len_ok;
      geo.zero  <= !(near && side6.len_ok) || (side6.sq == '0);
      geo.neg_x <= side6.neg_x;
      geo.neg_y <= side6.neg_y;
      geo.c2_x  <= side6.c2_x;
      geo.c2_y  <= side6.c2_y;
      geo.sq    <= side6.sq;
    end
  end

endmodule

@@ rtl/seg_unit.sv @@
// Pipelined bit-per-stage search for one rounded unit-normal component.
module seg_unit #(
  parameter int FRAC = 14
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [seg_pkg::C2W-1:0] c2,
  input  logic [seg_pkg::SQW-1:0] sq,
  input  logic                    neg,
  input  logic                    zero,
  input  logic                    tag,
  output logic                    out_valid,
  output logic                    out_tag,
  output logic signed [FRAC+1:0]  value
);
  import seg_pkg::*;

  localparam int SW = 2 * FRAC + 56;
  localparam int QW = FRAC + 1;
  localparam int VW = FRAC + 2;

  logic signed [SW-1:0] u_s   [0:FRAC+1];
  logic signed [SW-1:0] p_s   [0:FRAC+1];
  logic signed [SW-1:0] sq_s  [0:FRAC+1];
  logic signed [SW-1:0] rhs_s [0:FRAC+1];
  logic [QW-1:0]        q_s   [0:FRAC+1];
  logic                 v_s   [0:FRAC+1];
  logic                 neg_s [0:FRAC+1];
  logic                 zero_s[0:FRAC+1];
  logic                 tag_s [0:FRAC+1];

  // Stage entry: t = 0, so U = (2t-1)^2*sq = sq and P = (2t-1)*sq = -sq.
  assign u_s[0]    = SW'(sq);
  assign p_s[0]    = -SW'(sq);
  assign sq_s[0]   = SW'(sq);
  assign rhs_s[0]  = SW'(c2) << (2 * FRAC + 2);
  assign q_s[0]    = '0;
  assign v_s[0]    = in_valid;
  assign neg_s[0]  = neg;
  assign zero_s[0] = zero;
  assign tag_s[0]  = tag;

  for (genvar i = 0; i <= FRAC; i++) begin : g_step
    localparam int K = FRAC - i;
    logic signed [SW-1:0] cand;
    logic take;

    assign cand = u_s[i] + (p_s[i] <<< (K + 2)) + (sq_s[i] <<< (2 * K + 2));
    assign take = cand <= rhs_s[i];

    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[i+1] <= 1'b0;
      end else if (en) begin
        v_s[i+1] <= v_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        u_s[i+1]    <= take ? cand : u_s[i];
        p_s[i+1]    <= take ? p_s[i] + (sq_s[i] <<< (K + 1)) : p_s[i];
        q_s[i+1]    <= take ? (q_s[i] | (QW'(1) << K)) : q_s[i];
        sq_s[i+1]   <= sq_s[i];
        rhs_s[i+1]  <= rhs_s[i];
        neg_s[i+1]  <= neg_s[i];
        zero_s[i+1] <= zero_s[i];
        tag_s[i+1]  <= tag_s[i];
      end
    end
  end

  assign out_valid = v_s[FRAC+1];
  assign out_tag   = tag_s[FRAC+1];
  assign value     = zero_s[FRAC+1] ? '0 :
                     neg_s[FRAC+1] ? -VW'(q_s[FRAC+1]) : VW'(q_s[FRAC+1]);

endmodule

@@ rtl/seg_check.sv @@
// Port-level checker for the segment collision block and its bind to the top level.
module seg_check #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                hit,
  input logic signed [NORMAL_FRAC_BITS+1:0]  normal_x,
  input logic signed [NORMAL_FRAC_BITS+1:0]  normal_y
);

  localparam int LIM = 1 << NORMAL_FRAC_BITS;

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(normal_x) && $stable(normal_y))
    else $error("stalled output word changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> normal_x == 0 && normal_y == 0)
    else $error("normal not zero on a miss");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> normal_x <= LIM && normal_x >= -LIM && normal_y <= LIM && normal_y >= -LIM)
    else $error("normal component out of unit range");

  a_stall_only_held: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input blocked while no output word is held");

endmodule

bind segment_collision_normal seg_check #(.NORMAL_FRAC_BITS(NORMAL_FRAC_BITS)) u_seg_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit),
  .normal_x  (normal_x),
  .normal_y  (normal_y)
);
